// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks sampled on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sths_pkg.sv -----
// ---------------------------------------------------------------------------
// sths_pkg
// shared constants, types and helpers of the stack trace header stripper
// ---------------------------------------------------------------------------
`default_nettype none

package sths_pkg;

    localparam int LINE_CAPACITY = 62;
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int K_LEN = 13;
    localparam int U_LEN = 11;
    localparam logic [K_LEN*8-1:0] K_LABEL = {"kernel", "_stack:"};
    localparam logic [U_LEN*8-1:0] U_LABEL = "user_stack:";

    // prefix tracker for the "=>" marker
    localparam logic [1:0] ARW_LEAD = 2'd0;
    localparam logic [1:0] ARW_EQ   = 2'd1;
    localparam logic [1:0] ARW_YES  = 2'd2;
    localparam logic [1:0] ARW_NO   = 2'd3;

    // output byte source
    localparam logic [1:0] SEL_TAB  = 2'd0;
    localparam logic [1:0] SEL_DATA = 2'd1;
    localparam logic [1:0] SEL_LF   = 2'd2;

    typedef struct packed {
        logic       take;        // input request accepted
        logic       start_emit;  // load read index for the run
        logic       rd_en;       // read line store at the index
        logic       load_out;    // load output register
        logic [1:0] out_sel;
        logic       out_last;
        logic       idx_inc;
        logic       clear;       // end of line, clear line state
    } t_cmd;

    typedef struct packed {
        logic line_end;    // current input byte ends the line
        logic nl;          // line ended with a newline
        logic drop;
        logic user;
        logic user_empty;  // nothing stored after the user label
        logic at_end;      // read index reached line length
        logic last_idx;    // read index is the last stored byte
        logic out_free;
    } t_stat;

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == CH_SPACE) || (b == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sths_ram.sv -----
// ---------------------------------------------------------------------------
// sths_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module sths_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sths_dp.sv -----
// ---------------------------------------------------------------------------
// sths_dp
// line store, label matchers, read index and output register
// ---------------------------------------------------------------------------
`default_nettype none

module sths_dp
    import sths_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output      t_stat      o_stat,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_final,
    output      logic [7:0] o_byte,
    output      logic       o_last,
    output      logic       o_trunc,
    output      logic       o_valid,
    input  wire logic       i_ready
);

    logic [LEN_W-1:0]     r_len;
    logic                 r_ov;
    logic                 r_nl;
    logic [1:0]           r_arw;
    logic                 r_kfound;
    logic                 r_ufound;
    logic                 r_uskip;
    logic [LEN_W-1:0]     r_ustart;
    logic [K_LEN*8-1:0]   r_win;
    logic [LEN_W-1:0]     r_idx;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;
    logic                 r_out_trunc;

    logic                 is_lf;
    logic                 store;
    logic [K_LEN*8-1:0]   n_win;
    logic                 k_hit;
    logic                 u_hit;
    logic [1:0]           n_arw;
    logic [LEN_W-1:0]     len_inc;
    logic [7:0]           rd_data;
    logic [7:0]           n_out_byte;
    logic                 arrow;

    assign is_lf   = (i_byte == CH_LF);
    assign store   = i_cmd.take && !is_lf && (r_len < LEN_W'(LINE_CAPACITY));
    assign len_inc = r_len + LEN_W'(1);
    assign n_win   = {r_win[K_LEN*8-9:0], i_byte};
    assign k_hit   = (n_win == K_LABEL) && (r_len >= LEN_W'(K_LEN - 1));
    assign u_hit   = (n_win[U_LEN*8-1:0] == U_LABEL) && (r_len >= LEN_W'(U_LEN - 1));

    always_comb begin
        n_arw = r_arw;
        case (r_arw)
            ARW_LEAD: begin
                if (i_byte == CH_EQ) begin
                    n_arw = ARW_EQ;
                end else if (!is_blank(i_byte)) begin
                    n_arw = ARW_NO;
                end
            end
            ARW_EQ:  n_arw = (i_byte == CH_GT) ? ARW_YES : ARW_NO;
            default: n_arw = r_arw;
        endcase
    end

    sths_ram #(
        .WIDTH(8),
        .DEPTH(LINE_CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (store),
        .i_waddr(r_len[ADDR_W-1:0]),
        .i_wdata(i_byte),
        .i_re   (i_cmd.rd_en),
        .i_raddr(r_idx[ADDR_W-1:0]),
        .o_rdata(rd_data)
    );

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ov     <= 1'b0;
            r_nl     <= 1'b0;
            r_arw    <= ARW_LEAD;
            r_kfound <= 1'b0;
            r_ufound <= 1'b0;
            r_uskip  <= 1'b0;
        end else if (i_cmd.clear) begin
            r_len    <= '0;
            r_ov     <= 1'b0;
            r_nl     <= 1'b0;
            r_arw    <= ARW_LEAD;
            r_kfound <= 1'b0;
            r_ufound <= 1'b0;
            r_uskip  <= 1'b0;
        end else if (i_cmd.take) begin
            if (is_lf) begin
                r_nl <= 1'b1;
            end else if (!store) begin
                r_ov <= 1'b1;
            end
            if (store) begin
                r_len <= len_inc;
                r_arw <= n_arw;
                if (k_hit) begin
                    r_kfound <= 1'b1;
                end
                if (!r_ufound && u_hit) begin
                    r_ufound <= 1'b1;
                    r_uskip  <= 1'b1;
                end else if (r_ufound && r_uskip && !is_blank(i_byte)) begin
                    r_uskip <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_win <= n_win;
            // text after the label starts past any blanks
            if (!r_ufound && u_hit) begin
                r_ustart <= len_inc;
            end else if (r_ufound && r_uskip && is_blank(i_byte)) begin
                r_ustart <= len_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_emit) begin
            r_idx <= (!arrow && r_ufound && !r_kfound) ? r_ustart : '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + LEN_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            SEL_TAB:  n_out_byte = CH_TAB;
            SEL_DATA: n_out_byte = rd_data;
            SEL_LF:   n_out_byte = CH_LF;
            default:  n_out_byte = CH_LF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_byte  <= n_out_byte;
            r_out_last  <= i_cmd.out_last;
            r_out_trunc <= r_ov;
        end
    end

    assign arrow = (r_arw == ARW_YES);

    always_comb begin
        o_stat.line_end   = is_lf || i_final;
        o_stat.nl         = r_nl;
        o_stat.drop       = !arrow && r_kfound;
        o_stat.user       = !arrow && r_ufound && !r_kfound;
        o_stat.user_empty = (r_ustart == r_len);
        o_stat.at_end     = (r_idx == r_len);
        o_stat.last_idx   = ((r_idx + LEN_W'(1)) == r_len);
        o_stat.out_free   = !r_out_valid || i_ready;
    end

    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_trunc = r_out_trunc;
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/sths_ctrl.sv -----
// ---------------------------------------------------------------------------
// sths_ctrl
// sequencer: buffers bytes, then walks the line store to emit the run
// ---------------------------------------------------------------------------
`default_nettype none

module sths_ctrl
    import sths_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output      logic  o_ready,
    input  wire t_stat i_stat,
    output      t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_TAB   = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_DATA  = 3'd4;
    localparam logic [2:0] S_LF    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_sel = SEL_DATA;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.line_end) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.start_emit = 1'b1;
                if (i_stat.drop) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_stat.user) begin
                    n_state = S_TAB;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_TAB: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = SEL_TAB;
                    o_cmd.out_last = i_stat.user_empty && !i_stat.nl;
                    n_state        = S_ADDR;
                end
            end
            S_ADDR: begin
                if (!i_stat.at_end) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_DATA;
                end else if (i_stat.nl) begin
                    n_state = S_LF;
                end else begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DATA: begin
                // read data holds until the next read
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = SEL_DATA;
                    o_cmd.out_last = i_stat.last_idx && !i_stat.nl;
                    o_cmd.idx_inc  = 1'b1;
                    n_state        = S_ADDR;
                end
            end
            S_LF: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = SEL_LF;
                    o_cmd.out_last = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/stack_trace_header_stripper.sv -----
// ---------------------------------------------------------------------------
// stack_trace_header_stripper: per-line filter of a text byte stream
// one byte per cycle inside a line; a line end then holds the input while the
// block decides, emits a tab for a user stack line, reads and emits each stored
// byte, finds the end and emits a newline if the line had one; sync reset
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stack_trace_header_stripper
    import sths_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output      logic       o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,   // in_final
    output      logic       o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output      logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output      logic       o_m_axis_tlast,   // out_run_end
    output      logic       o_m_axis_tuser    // [0] out_truncated
);

    t_cmd  cmd;
    t_stat stat;

    sths_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .o_ready(o_s_axis_tready),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    sths_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_stat (stat),
        .i_byte (i_s_axis_tdata),
        .i_final(i_s_axis_tlast),
        .o_byte (o_m_axis_tdata),
        .o_last (o_m_axis_tlast),
        .o_trunc(o_m_axis_tuser),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready)
    );

    `ASSERT_NEXT(a_busy_after_line_end, i_s_axis_tvalid && o_s_axis_tready && stat.line_end, !o_s_axis_tready, "input request taken while a line is processed")
    `ASSERT_IMPL(a_no_overwrite, cmd.load_out, stat.out_free, "output register overwritten")
    `ASSERT_IMPL(a_read_in_range, cmd.rd_en, !stat.at_end, "line store read beyond line length")

endmodule

`default_nettype wire
